### rtl/fpiir_pkg.sv
// fpiir_pkg: shared constants and types for the direct form I iir filter
// no dependencies
`timescale 1ns / 1ps

package fpiir_pkg;

  localparam int unsigned SampleW = 16;
  localparam int unsigned CoeffW  = 16;
  localparam int unsigned ExpW    = 4;
  localparam int unsigned TapsW   = 4;
  localparam int unsigned CfgW    = 64;
  localparam int unsigned CfgIdxW = 3;
  // product is 32 bits, sum of up to 16 products plus 15-bit alignment
  localparam int unsigned AccW    = 52;

  typedef enum logic [CfgIdxW-1:0] {
    REG_NUM_TAPS  = 3'd0,
    REG_DEN_TAPS  = 3'd1,
    REG_NUM_EXP   = 3'd2,
    REG_DEN_EXP   = 3'd3,
    REG_NUM_LO    = 3'd4,
    REG_NUM_HI    = 3'd5,
    REG_DEN_LO    = 3'd6,
    REG_DEN_HI    = 3'd7
  } cfg_reg_e;

  // control from sequencer to multiplier
  typedef struct packed {
    logic start;
    logic neg;
  } mul_ctrl_t;

endpackage

### rtl/fpiir_mul.sv
// fpiir_mul: bit-serial signed 16x16 multiplier, one multiplier bit per cycle
// depends on fpiir_pkg
`timescale 1ns / 1ps

module fpiir_mul import fpiir_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  mul_ctrl_t                ctrl_i,
  input  logic signed [CoeffW-1:0] coeff_i,
  input  logic signed [SampleW-1:0] data_i,
  output logic                     done_o,
  output logic signed [2*SampleW-1:0] prod_o
);

  localparam int unsigned CntW = $clog2(SampleW + 1);

  logic signed [2*SampleW-1:0] acc_q, acc_d, mcand_q, mcand_d;
  logic [SampleW-1:0] mplier_q, mplier_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic busy_q, busy_d, neg_q, neg_d;
  logic signed [2*SampleW-1:0] addend;

  // shift-add over multiplier bits; msb carries negative weight
  always_comb begin
    acc_d = acc_q; mcand_d = mcand_q; mplier_d = mplier_q;
    cnt_d = cnt_q; busy_d = busy_q; neg_d = neg_q;
    addend = mplier_q[0] ? mcand_q : '0;
    if (ctrl_i.start) begin
      acc_d    = '0;
      mcand_d  = {{SampleW{coeff_i[CoeffW-1]}}, coeff_i};
      mplier_d = data_i;
      cnt_d    = '0;
      busy_d   = 1'b1;
      neg_d    = ctrl_i.neg;
    end else if (busy_q) begin
      if (cnt_q == CntW'(SampleW - 1)) begin
        acc_d  = acc_q - addend;
        busy_d = 1'b0;
      end else begin
        acc_d = acc_q + addend;
      end
      mcand_d  = mcand_q <<< 1;
      mplier_d = mplier_q >> 1;
      cnt_d    = cnt_q + CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      neg_q  <= 1'b0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
      neg_q  <= neg_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q    <= acc_d;
    mcand_q  <= mcand_d;
    mplier_q <= mplier_d;
  end

  assign done_o = busy_q && (cnt_q == CntW'(SampleW - 1));
  assign prod_o = neg_q ? -acc_d : acc_d;

endmodule

### rtl/fixed_point_iir_direct_form_one.sv
// fixed_point_iir_direct_form_one: direct form i iir filter, top level
// sequence: accept in idle, then issue and wait for each active tap product from the
// bit-serial multiplier, then align, round and output; n numerator and d-1 feedback products
// one sample at a time: no new sample is taken until the last is output; a result not yet taken
// holds the following sample in the output state until the output is free
// reset: histories cleared, config to 1 tap each and exponent 14, coeffs zero
`timescale 1ns / 1ps

module fixed_point_iir_direct_form_one import fpiir_pkg::*; #(
  parameter int unsigned MAX_TAPS = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [15:0]         s_axis_tdata,  // sample_in[15:0]
  input  logic                s_axis_tlast,  // block_end
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [15:0]         m_axis_tdata,  // sample_out[15:0]
  output logic                m_axis_tlast,  // last_out
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgW-1:0]     cfg_data_i
);

  localparam int unsigned HistD = MAX_TAPS - 1;
  localparam int unsigned JW    = $clog2(MAX_TAPS + 1);

  typedef enum logic [2:0] {S_IDLE, S_ISSUE, S_WAIT, S_ALIGN, S_ROUND, S_OUT} state_e;

  // configuration registers
  logic [TapsW-1:0] ntaps_q, dtaps_q;
  logic [ExpW-1:0]  nexp_q, dexp_q;
  logic [CfgW-1:0]  nlo_q, nhi_q, dlo_q, dhi_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ntaps_q <= TapsW'(1); dtaps_q <= TapsW'(1);
      nexp_q  <= ExpW'(14); dexp_q  <= ExpW'(14);
      nlo_q <= '0; nhi_q <= '0; dlo_q <= '0; dhi_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_NUM_TAPS: ntaps_q <= cfg_data_i[TapsW-1:0];
        REG_DEN_TAPS: dtaps_q <= cfg_data_i[TapsW-1:0];
        REG_NUM_EXP:  nexp_q  <= cfg_data_i[ExpW-1:0];
        REG_DEN_EXP:  dexp_q  <= cfg_data_i[ExpW-1:0];
        REG_NUM_LO:   nlo_q   <= cfg_data_i;
        REG_NUM_HI:   nhi_q   <= cfg_data_i;
        REG_DEN_LO:   dlo_q   <= cfg_data_i;
        REG_DEN_HI:   dhi_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // clamped counts and alignment
  logic [JW-1:0] nt, dt;
  logic [ExpW-1:0] emax;
  assign nt = (ntaps_q > TapsW'(MAX_TAPS)) ? JW'(MAX_TAPS) : JW'(ntaps_q);
  assign dt = (dtaps_q > TapsW'(MAX_TAPS)) ? JW'(MAX_TAPS) : JW'(dtaps_q);
  assign emax = (nexp_q > dexp_q) ? nexp_q : dexp_q;

  state_e state_q;
  logic phase_q;                 // 0 numerator, 1 feedback
  logic [JW-1:0] j_q;
  logic signed [SampleW-1:0] x_q;
  logic last_q;
  logic signed [SampleW-1:0] xh_q [HistD];
  logic signed [SampleW-1:0] yh_q [HistD];
  logic signed [AccW-1:0] num_q, den_q, tot_q;
  logic [SampleW-1:0] y_q;
  logic ovalid_q;
  logic out_go;

  // coefficient and operand select
  logic [2*CfgW-1:0] nwords, dwords;
  logic [2:0] k;
  logic signed [CoeffW-1:0] coeff;
  logic signed [SampleW-1:0] opnd;
  assign nwords = {nhi_q, nlo_q};
  assign dwords = {dhi_q, dlo_q};
  assign k = j_q[2:0];
  assign coeff = phase_q ? dwords[k*CoeffW +: CoeffW] : nwords[k*CoeffW +: CoeffW];
  always_comb begin
    if (phase_q) opnd = yh_q[k - 3'd1];
    else if (j_q == '0) opnd = x_q;
    else opnd = xh_q[k - 3'd1];
  end

  mul_ctrl_t mctl;
  logic mdone;
  logic signed [2*SampleW-1:0] prod;
  assign mctl.start = (state_q == S_ISSUE);
  assign mctl.neg   = 1'b0;

  fpiir_mul u_mul (
    .clk_i, .rst_ni, .ctrl_i(mctl), .coeff_i(coeff), .data_i(opnd),
    .done_o(mdone), .prod_o(prod)
  );

  // input taken whenever idle; output register frees as its result is taken
  assign s_axis_tready = (state_q == S_IDLE);
  assign out_go = (state_q == S_OUT) && (!ovalid_q || m_axis_tready);

  logic signed [AccW-1:0] rnd, shifted;
  assign rnd = (emax == '0) ? '0 : (AccW'(1) <<< (emax - ExpW'(1)));
  assign shifted = tot_q >>> emax;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; phase_q <= 1'b0; j_q <= '0; ovalid_q <= 1'b0;
      for (int i = 0; i < HistD; i++) begin
        xh_q[i] <= '0; yh_q[i] <= '0;
      end
    end else begin
      if (out_go) ovalid_q <= 1'b1;
      else if (ovalid_q && m_axis_tready) ovalid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: if (s_axis_tvalid && s_axis_tready) begin
          x_q <= s_axis_tdata; last_q <= s_axis_tlast;
          num_q <= '0; den_q <= '0; j_q <= '0; phase_q <= 1'b0;
          if (nt != '0) state_q <= S_ISSUE;
          else if (dt > JW'(1)) begin
            phase_q <= 1'b1; j_q <= JW'(1); state_q <= S_ISSUE;
          end else state_q <= S_ALIGN;
        end
        S_ISSUE: state_q <= S_WAIT;
        S_WAIT: if (mdone) begin
          if (!phase_q) begin
            num_q <= num_q + AccW'(prod);
            if (j_q + JW'(1) < nt) begin
              j_q <= j_q + JW'(1); state_q <= S_ISSUE;
            end else if (dt > JW'(1)) begin
              phase_q <= 1'b1; j_q <= JW'(1); state_q <= S_ISSUE;
            end else state_q <= S_ALIGN;
          end else begin
            den_q <= den_q + AccW'(prod);
            if (j_q + JW'(1) < dt) begin
              j_q <= j_q + JW'(1); state_q <= S_ISSUE;
            end else state_q <= S_ALIGN;
          end
        end
        S_ALIGN: begin
          tot_q <= (num_q <<< (emax - nexp_q)) - (den_q <<< (emax - dexp_q));
          state_q <= S_ROUND;
        end
        S_ROUND: begin
          tot_q <= tot_q + rnd;
          state_q <= S_OUT;
        end
        S_OUT: if (out_go) begin
          if (shifted > AccW'(32767)) y_q <= 16'h7fff;
          else if (shifted < -AccW'(32768)) y_q <= 16'h8000;
          else y_q <= shifted[SampleW-1:0];
          state_q <= S_IDLE;
          for (int i = HistD - 1; i > 0; i--) begin
            xh_q[i] <= last_q ? '0 : xh_q[i-1];
            yh_q[i] <= last_q ? '0 : yh_q[i-1];
          end
          xh_q[0] <= last_q ? '0 : x_q;
          if (last_q) yh_q[0] <= '0;
          else if (shifted > AccW'(32767)) yh_q[0] <= 16'sh7fff;
          else if (shifted < -AccW'(32768)) yh_q[0] <= 16'sh8000;
          else yh_q[0] <= shifted[SampleW-1:0];
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_go) m_axis_tlast <= last_q;
  end

  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = y_q;

`ifndef SYNTHESIS
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> !s_axis_tready) else $error("accept while busy");
  a_out_after_round: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_OUT) |=> ovalid_q) else $error("result not raised");
  a_mul_done_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mdone |-> (state_q == S_WAIT)) else $error("multiplier done out of step");
`endif

endmodule

### sim/tb.sv
// tb: self-checking testbench for the fixed_point_iir_direct_form_one filter
// drives sample streams and register writes, predicts every filtered sample
// depends on fpiir_pkg and the filter rtl
`timescale 1ns / 1ps

module tb;
  import fpiir_pkg::*;

  typedef struct packed {
    logic signed [15:0] smp;
    logic               last;
  } sample_t;

  localparam int unsigned SettleCycles = 300;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [15:0]       s_axis_tdata = '0;
  logic              s_axis_tlast = 1'b0;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [15:0]       m_axis_tdata;
  logic              m_axis_tlast;
  logic              cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i = '0;
  logic [CfgW-1:0]   cfg_data_i = '0;

  // shadow of the filter settings and histories
  logic [3:0]          sh_num_taps, sh_den_taps, sh_num_exp, sh_den_exp;
  logic [63:0]         sh_num_lo, sh_num_hi, sh_den_lo, sh_den_hi;
  logic signed [15:0]  x_hist [7];
  logic signed [15:0]  y_hist [7];

  sample_t pending_samples[$];
  sample_t expected_samples[$];
  int      send_idle = 0;
  int      recv_idle = 0;
  int      long_stall_req = 0;
  int      long_stall_done = 0;
  int      stall_left = 0;
  int      fail_count = 0;

  fixed_point_iir_direct_form_one #(.MAX_TAPS(8)) i_dut (.*);

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #(3_000_000 * 20);
    $display("Regression FAIL");
    $finish;
  end

  function automatic logic signed [15:0] coeff_at(logic [63:0] lo, logic [63:0] hi, int k);
    logic [63:0] w;
    w = (k < 4) ? lo : hi;
    return w[16*(k%4) +: 16];
  endfunction

  function automatic void clear_history();
    for (int i = 0; i < 7; i++) begin
      x_hist[i] = '0;
      y_hist[i] = '0;
    end
  endfunction

  // direct form i step: numerator minus feedback, round, shift, saturate
  function automatic logic signed [15:0] filter_step(logic signed [15:0] x, logic last);
    int     nt, dt, ne, de, e;
    longint num_sum, fb_sum, total;
    logic signed [15:0] y;
    nt = (sh_num_taps > 8) ? 8 : sh_num_taps;
    dt = (sh_den_taps > 8) ? 8 : sh_den_taps;
    ne = sh_num_exp;
    de = sh_den_exp;
    e  = (ne > de) ? ne : de;
    num_sum = 0;
    fb_sum = 0;
    for (int j = 0; j < nt; j++)
      num_sum += longint'(coeff_at(sh_num_lo, sh_num_hi, j)) *
                 longint'((j == 0) ? x : x_hist[j-1]);
    for (int j = 1; j < dt; j++)
      fb_sum += longint'(coeff_at(sh_den_lo, sh_den_hi, j)) * longint'(y_hist[j-1]);
    total = (num_sum <<< (e - ne)) - (fb_sum <<< (e - de));
    if (e > 0) total += longint'(1) <<< (e - 1);
    total = total >>> e;
    if (total > 32767) total = 32767;
    else if (total < -32768) total = -32768;
    y = total[15:0];
    for (int j = 6; j > 0; j--) begin
      x_hist[j] = x_hist[j-1];
      y_hist[j] = y_hist[j-1];
    end
    x_hist[0] = x;
    y_hist[0] = y;
    if (last) clear_history();
    return y;
  endfunction

  // sender: offers queued samples, predicts on each accepted transfer
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      sample_t nxt;
      if (s_axis_tvalid && s_axis_tready)
        expected_samples.push_back({filter_step(s_axis_tdata, s_axis_tlast), s_axis_tlast});
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending_samples.size() > 0 && $urandom_range(99) >= send_idle) begin
          nxt = pending_samples.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= nxt.smp;
          s_axis_tlast  <= nxt.last;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver: random backpressure, long hold-off on request, result check
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      sample_t exp_s;
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_samples.size() == 0) begin
          $error("unexpected output transfer: sample_out %0d", $signed(m_axis_tdata));
          fail_count++;
        end else begin
          exp_s = expected_samples.pop_front();
          if (m_axis_tdata !== exp_s.smp) begin
            $error("sample_out: expected %0d, actual %0d", exp_s.smp, $signed(m_axis_tdata));
            fail_count++;
          end
          if (m_axis_tlast !== exp_s.last) begin
            $error("last_out: expected %0b, actual %0b", exp_s.last, m_axis_tlast);
            fail_count++;
          end
        end
      end
      if (long_stall_req != long_stall_done) begin
        long_stall_done++;
        stall_left = 600;
      end
      if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle);
      end
    end
  end

  task automatic cfg_write(cfg_reg_e idx, logic [63:0] val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    case (idx)
      REG_NUM_TAPS: sh_num_taps = val[3:0];
      REG_DEN_TAPS: sh_den_taps = val[3:0];
      REG_NUM_EXP:  sh_num_exp  = val[3:0];
      REG_DEN_EXP:  sh_den_exp  = val[3:0];
      REG_NUM_LO:   sh_num_lo   = val;
      REG_NUM_HI:   sh_num_hi   = val;
      REG_DEN_LO:   sh_den_lo   = val;
      default:      sh_den_hi   = val;
    endcase
  endtask

  task automatic set_filter(int nt, int dt, int ne, int de,
                            logic [63:0] nlo, logic [63:0] nhi,
                            logic [63:0] dlo, logic [63:0] dhi);
    cfg_write(REG_NUM_TAPS, 64'(nt));
    cfg_write(REG_DEN_TAPS, 64'(dt));
    cfg_write(REG_NUM_EXP, 64'(ne));
    cfg_write(REG_DEN_EXP, 64'(de));
    cfg_write(REG_NUM_LO, nlo);
    cfg_write(REG_NUM_HI, nhi);
    cfg_write(REG_DEN_LO, dlo);
    cfg_write(REG_DEN_HI, dhi);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_samples.size() > 0 || s_axis_tvalid || expected_samples.size() > 0)
      @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  function automatic logic [63:0] rand_coeffs();
    logic [63:0] w;
    for (int k = 0; k < 4; k++)
      w[16*k +: 16] = ($urandom_range(2) == 0) ? 16'($urandom)
                    : 16'($signed(16'($urandom_range(4095))) - 2048);
    return w;
  endfunction

  // blocks of 1 to 30 samples ending in block_end (the final one may be cut short), with some stray marks as noise
  task automatic push_random(int n);
    int left;
    left = 0;
    for (int i = 0; i < n; i++) begin
      if (left == 0) left = $urandom_range(1, 30);
      left--;
      pending_samples.push_back({16'($urandom),
                                 (left == 0) || ($urandom_range(19) == 0)});
    end
  endtask

  initial begin
    sample_t corner[$];
    clear_history();
    sh_num_taps = 1; sh_den_taps = 1; sh_num_exp = 14; sh_den_exp = 14;
    sh_num_lo = '0; sh_num_hi = '0; sh_den_lo = '0; sh_den_hi = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset settings give zero coefficients
    pending_samples.push_back({16'sd32767, 1'b0});
    pending_samples.push_back({-16'sd32768, 1'b1});
    wait_drained();

    // full taps, largest exponents, extreme coefficients: saturation both ways
    set_filter(8, 8, 15, 15, {4{16'h8000}}, {4{16'h8000}}, {4{16'h7fff}}, {4{16'h7fff}});
    corner = '{{16'sd32767, 1'b0}, {-16'sd32768, 1'b0}, {16'sd0, 1'b0}, {-16'sd1, 1'b0},
               {16'sd1, 1'b1}, {16'sd32767, 1'b0}, {16'sd32767, 1'b0},
               {-16'sd32768, 1'b1}, {16'sd1, 1'b0}};
    foreach (corner[i]) pending_samples.push_back(corner[i]);
    wait_drained();

    // zero tap counts and zero exponents: no numerator, no feedback, no rounding
    set_filter(0, 0, 0, 0, rand_coeffs(), rand_coeffs(), rand_coeffs(), rand_coeffs());
    pending_samples.push_back({16'sd12345, 1'b0});
    pending_samples.push_back({-16'sd7, 1'b1});
    wait_drained();

    // tap counts above the maximum, mixed exponents
    set_filter(15, 15, 0, 15, rand_coeffs(), rand_coeffs(), rand_coeffs(), rand_coeffs());
    for (int i = 0; i < 5; i++) pending_samples.push_back({16'($urandom), i == 4});
    wait_drained();
    set_filter(1, 1, 15, 1, {48'd0, 16'h7fff}, '0, '1, '1);
    pending_samples.push_back({16'sd32767, 1'b0});
    pending_samples.push_back({-16'sd32768, 1'b0});
    pending_samples.push_back({16'sd3, 1'b1});
    wait_drained();

    // random settings, idling pattern changes by phase
    for (int ph = 0; ph < 9; ph++) begin
      send_idle = (ph < 3) ? 23 : (ph < 6) ? 52 : 0;
      recv_idle = (ph < 3) ? 52 : (ph < 6) ? 23 : 0;
      set_filter($urandom_range(15), $urandom_range(15), $urandom_range(15),
                 $urandom_range(15), rand_coeffs(), rand_coeffs(), rand_coeffs(),
                 rand_coeffs());
      if (ph == 1) begin
        // sender pauses until the pipeline has drained
        push_random(30);
        while (pending_samples.size() > 0 || expected_samples.size() > 0)
          @(posedge clk_i);
        push_random(30);
      end else begin
        push_random(58);
        if (ph == 4) long_stall_req++;
      end
      wait_drained();
    end

    if (fail_count == 0 && expected_samples.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
